// File: sv/igpd_pkg.sv
package igpd_pkg;
  localparam int SOURCES = 8;
  localparam int EVENTS = 3;
  localparam int STEPS = 4;
  localparam int LOG_DEPTH = 4;
  localparam int LEN_W = 3;
  localparam int TIME_W = 32;

  typedef enum logic [2:0] {
    REG_EV0_MIN = 3'd0, REG_EV0_MAX = 3'd1, REG_EV1_MIN = 3'd2,
    REG_EV1_MAX = 3'd3, REG_EV2_MIN = 3'd4, REG_EV2_MAX = 3'd5,
    REG_SHAPE = 3'd6, REG_SMASK = 3'd7
  } reg_idx_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                     level;
    logic [TIME_W-1:0]        now;
  } tick_t;

  typedef struct packed {
    logic [2:0]               fired;
    logic                     level;
    logic                     changed;
  } result_t;
endpackage

// File: sv/igpd_front.sv
module igpd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          stall,
  input  logic [igpd_pkg::SOURCES-1:0]  source_levels,
  input  logic [igpd_pkg::TIME_W-1:0]   now_ms,
  input  logic [igpd_pkg::SOURCES-1:0]  smask,
  output logic                          q_valid,
  input  logic                          q_pop,
  output igpd_pkg::tick_t               q_head
);
  // two-entry queue of classified ticks
  igpd_pkg::tick_t mem [2];
  logic            wp, rp;
  logic [1:0]      cnt;
  logic            push;
  igpd_pkg::tick_t t;

  always_comb begin
    t.level = ((source_levels & smask) == smask);
    t.now = now_ms;
  end

  assign stall = (cnt == 2'd2);
  assign push = valid && !stall;
  assign q_valid = (cnt != 2'd0);
  assign q_head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= t;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_nopop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_push_cnt: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> cnt == $past(cnt) + 2'd1)
    else $error("queue count missed push");
endmodule

// File: sv/igpd_back.sv
module igpd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  igpd_pkg::tick_t              q_head,
  input  logic [63:0]                  min_t [igpd_pkg::EVENTS],
  input  logic [63:0]                  max_t [igpd_pkg::EVENTS],
  input  logic [24:0]                  shape,
  output logic                         o_valid,
  input  logic                         o_stall,
  output igpd_pkg::result_t            o_res
);
  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_OUT} state_t;
  state_t state;

  logic                        h_lvl [igpd_pkg::LOG_DEPTH];
  logic [igpd_pkg::TIME_W-1:0] h_tim [igpd_pkg::LOG_DEPTH];
  logic [2:0]                  cntr [igpd_pkg::EVENTS];
  logic [1:0]                  ev;
  igpd_pkg::tick_t             cur;
  logic                        chg;
  logic [2:0]                  fired;
  logic                        match;

  // one event per cycle, steps checked in parallel
  always_comb begin
    logic [7:0]  f;
    logic [2:0]  len;
    logic [31:0] el;
    logic [15:0] mn, mx;
    f = shape[8*ev+1 +: 8];
    len = f[3:1];
    mn = '0;
    mx = '0;
    el = '0;
    match = f[0] && len != 3'd0 && len <= 3'(igpd_pkg::STEPS) && cntr[ev] >= len;
    for (int i = 0; i < igpd_pkg::STEPS; i++) begin
      if (i < len) begin
        mn = min_t[ev][16*(len-1-i) +: 16];
        mx = max_t[ev][16*(len-1-i) +: 16];
        el = (i == 0) ? cur.now - h_tim[0] : h_tim[i-1] - h_tim[i];
        if (f[4+len-1-i] != h_lvl[i]) match = 1'b0;
        if (el < {16'd0, mn}) match = 1'b0;
        if (i != 0 && mx != 16'd0 && el >= {16'd0, mx}) match = 1'b0;
      end
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;
  assign o_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ev <= '0;
      for (int i = 0; i < igpd_pkg::LOG_DEPTH; i++) begin
        h_lvl[i] <= 1'b0;
        h_tim[i] <= '0;
      end
      for (int e = 0; e < igpd_pkg::EVENTS; e++) cntr[e] <= '0;
    end else begin
      case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_head;
          fired <= '0;
          ev <= '0;
          chg <= 1'b0;
          o_res.level <= q_head.level;
          if (shape[0]) begin
            state <= S_EVAL;
            if (q_head.level != h_lvl[0]) begin
              chg <= 1'b1;
              for (int i = igpd_pkg::LOG_DEPTH-1; i > 0; i--) begin
                h_lvl[i] <= h_lvl[i-1];
                h_tim[i] <= h_tim[i-1];
              end
              h_lvl[0] <= q_head.level;
              h_tim[0] <= q_head.now;
              for (int e = 0; e < igpd_pkg::EVENTS; e++)
                if (cntr[e] < 3'(igpd_pkg::STEPS)) cntr[e] <= cntr[e] + 3'd1;
            end
          end else begin
            o_res.fired <= '0;
            o_res.changed <= 1'b0;
            state <= S_OUT;
          end
        end
        S_EVAL: begin
          if (match) begin
            fired[ev] <= 1'b1;
            cntr[ev] <= '0;
          end
          if (ev == 2'(igpd_pkg::EVENTS-1)) begin
            o_res.fired <= fired | (match ? (3'd1 << ev) : 3'd0);
            o_res.changed <= chg;
            state <= S_OUT;
          end else ev <= ev + 2'd1;
        end
        S_OUT: if (!o_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |=> state != S_IDLE)
    else $error("pop did not start work");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_stall) |=> o_valid && $stable(o_res))
    else $error("result dropped under stall");
  a_ev: assert property (@(posedge clk) disable iff (rst) ev < 2'(igpd_pkg::EVENTS))
    else $error("event index out of range");
endmodule

// File: sv/input_gesture_pattern_detector_top.sv
// gesture pattern detector for one button channel
// input channel: valid/stall, word = source_levels + now_ms, one per tick
// output channel: valid/stall, word = fired_mask, channel_level, level_changed
// one result word for every input word, in order
// configuration: apb, 64-bit data, register i at byte address 8*i, to be
// written only while the block is idle (not enforced); pready is always high
// front: forms the channel level, pushes into a two-entry queue
// back: shifts history on a level change, then checks one event per cycle
// after accept, the back pops the word from the queue with history update,
// then runs the three event checks and presents the result; when the channel
// is disabled it presents the result straight after the pop; the back takes
// the next word from the queue only once the result has been taken
// receiver stall: the result is held; the queue fills, then input stalls
// reset: history cleared to level low time 0, counters and registers zero
module input_gesture_pattern_detector_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  source_levels,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  fired_mask,
  output logic        channel_level,
  output logic        level_changed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [63:0] min_t [igpd_pkg::EVENTS];
  logic [63:0] max_t [igpd_pkg::EVENTS];
  logic [24:0] shape;
  logic [7:0]  smask;
  logic        q_valid, q_pop;
  igpd_pkg::tick_t   q_head;
  igpd_pkg::result_t res;
  igpd_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign idx = igpd_pkg::reg_idx_t'(paddr[5:3]);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < igpd_pkg::EVENTS; e++) begin
        min_t[e] <= '0;
        max_t[e] <= '0;
      end
      shape <= '0;
      smask <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        igpd_pkg::REG_EV0_MIN: min_t[0] <= pwdata;
        igpd_pkg::REG_EV0_MAX: max_t[0] <= pwdata;
        igpd_pkg::REG_EV1_MIN: min_t[1] <= pwdata;
        igpd_pkg::REG_EV1_MAX: max_t[1] <= pwdata;
        igpd_pkg::REG_EV2_MIN: min_t[2] <= pwdata;
        igpd_pkg::REG_EV2_MAX: max_t[2] <= pwdata;
        igpd_pkg::REG_SHAPE:   shape <= pwdata[24:0];
        igpd_pkg::REG_SMASK:   smask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      igpd_pkg::REG_EV0_MIN: prdata = min_t[0];
      igpd_pkg::REG_EV0_MAX: prdata = max_t[0];
      igpd_pkg::REG_EV1_MIN: prdata = min_t[1];
      igpd_pkg::REG_EV1_MAX: prdata = max_t[1];
      igpd_pkg::REG_EV2_MIN: prdata = min_t[2];
      igpd_pkg::REG_EV2_MAX: prdata = max_t[2];
      igpd_pkg::REG_SHAPE:   prdata = {39'd0, shape};
      igpd_pkg::REG_SMASK:   prdata = {56'd0, smask};
      default:               prdata = '0;
    endcase
  end

  igpd_front u_front (
    .clk, .rst, .valid, .stall, .source_levels, .now_ms, .smask,
    .q_valid, .q_pop, .q_head
  );

  igpd_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_head, .min_t, .max_t, .shape,
    .o_valid(out_valid), .o_stall(out_stall), .o_res(res)
  );

  assign fired_mask = res.fired;
  assign channel_level = res.level;
  assign level_changed = res.changed;
endmodule
